[hw/rtl/md5de_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Shared types, initial chaining values and the per-round constant tables.
// ----------------------------------------------------------------------------
package md5de_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } regs_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] PAD_MARKER = 32'h0000_0080;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0: idx = r4;
      2'd1: idx = r4 + {r4[1:0], 2'b00} + 4'd1;
      2'd2: idx = r4 + {r4[2:0], 1'b0} + 4'd5;
      default: idx = {r4[0], 3'b000} - r4;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    return ROT_AMT[{rnd[5:4], rnd[1:0]}];
  endfunction

endpackage

[hw/rtl/md5_digest_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine
// Streaming MD5 of a message given as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// The input channel (item_valid, item_stall) carries data_word, byte_count
// and last. Every item but the last must hold four bytes; the last holds
// zero to four. The output channel (digest_valid, digest_stall) carries one
// item per message: the 128-bit digest as digest_high and digest_low.
// Message words go into a 16-entry block memory, one item per cycle while
// a block fills. A full block then passes through a step that primes the
// memory read, 64 rounds at one round per cycle, and a step that adds into
// the chaining values. No item is taken during these steps, so throughput
// is set by the single round unit and the memory read port.
// After the last item, padding words are written one per cycle (up to 18)
// into one or two final blocks, each compressed in turn. The digest
// sits in an output register, so the next message is taken while a stalled
// digest waits; only a second digest finished behind a stalled one holds
// the engine. Synchronous reset restores the initial chaining values and
// drops any pending digest.
// ----------------------------------------------------------------------------
module md5_digest_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_PRIME,
    S_COMP,
    S_ADD,
    S_DONE
  } state_t;

  state_t           state;
  md5de_pkg::regs_t chain;
  md5de_pkg::regs_t work;
  md5de_pkg::regs_t round_out;
  logic [63:0]      bit_length;
  logic [3:0]       pos;
  logic [5:0]       rnd;
  logic             marker_pending;
  logic             no_len;
  logic             finishing;
  logic             final_block;

  logic [31:0]      buf_mem [16];
  logic [31:0]      rd_data;
  logic [3:0]       rd_addr;
  logic             wr_en;
  logic [3:0]       wr_addr;
  logic [31:0]      wr_data;

  logic             accept;
  logic [2:0]       cnt_eff;
  logic [31:0]      masked_word;
  logic [31:0]      marker_word;
  logic [63:0]      len_add;

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;

  always_comb begin
    if (!last || byte_count > 3'd4) begin
      cnt_eff = 3'd4;
    end else begin
      cnt_eff = byte_count;
    end
    case (cnt_eff)
      3'd0: begin
        masked_word = 32'h0;
        marker_word = md5de_pkg::PAD_MARKER;
      end
      3'd1: begin
        masked_word = {24'h0, data_word[7:0]};
        marker_word = md5de_pkg::PAD_MARKER << 8;
      end
      3'd2: begin
        masked_word = {16'h0, data_word[15:0]};
        marker_word = md5de_pkg::PAD_MARKER << 16;
      end
      3'd3: begin
        masked_word = {8'h0, data_word[23:0]};
        marker_word = md5de_pkg::PAD_MARKER << 24;
      end
      default: begin
        masked_word = data_word;
        marker_word = 32'h0;
      end
    endcase
    len_add = {58'd0, cnt_eff, 3'b000};
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = masked_word | marker_word;
    if (state == S_IDLE) begin
      wr_en = accept;
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (marker_pending) begin
        wr_data = md5de_pkg::PAD_MARKER;
      end else if (no_len) begin
        wr_data = 32'h0;
      end else if (pos == 4'd14) begin
        wr_data = bit_length[31:0];
      end else if (pos == 4'd15) begin
        wr_data = bit_length[63:32];
      end else begin
        wr_data = 32'h0;
      end
    end
  end

  assign rd_addr = (state == S_COMP) ? md5de_pkg::msg_index(rnd + 6'd1)
                                     : md5de_pkg::msg_index(rnd);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= wr_data;
    end
    rd_data <= buf_mem[rd_addr];
  end

  md5de_round u_round (
    .rnd (rnd),
    .cur (work),
    .msg (rd_data),
    .nxt (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      chain          <= '{md5de_pkg::INIT_A, md5de_pkg::INIT_B,
                          md5de_pkg::INIT_C, md5de_pkg::INIT_D};
      work           <= '0;
      bit_length     <= 64'd0;
      pos            <= 4'd0;
      rnd            <= 6'd0;
      marker_pending <= 1'b0;
      no_len         <= 1'b0;
      finishing      <= 1'b0;
      final_block    <= 1'b0;
      digest_valid   <= 1'b0;
    end else begin
      if (digest_valid && !digest_stall && state != S_DONE) begin
        digest_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            bit_length <= bit_length + len_add;
            pos        <= pos + 4'd1;
            if (last) begin
              finishing      <= 1'b1;
              final_block    <= 1'b0;
              marker_pending <= (cnt_eff == 3'd4);
              no_len         <= (cnt_eff != 3'd4) && (pos == 4'd14);
              state          <= (pos == 4'd15) ? S_PRIME : S_PAD;
            end else if (pos == 4'd15) begin
              finishing <= 1'b0;
              state     <= S_PRIME;
            end
          end
        end
        S_PAD: begin
          pos <= pos + 4'd1;
          if (marker_pending) begin
            marker_pending <= 1'b0;
            no_len         <= (pos[3:1] == 3'b111);
            if (pos == 4'd15) begin
              state <= S_PRIME;
            end
          end else if (pos == 4'd15) begin
            final_block <= !no_len;
            state       <= S_PRIME;
          end
        end
        S_PRIME: begin
          work  <= chain;
          rnd   <= 6'd0;
          state <= S_COMP;
        end
        S_COMP: begin
          work <= round_out;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain.a <= chain.a + work.a;
          chain.b <= chain.b + work.b;
          chain.c <= chain.c + work.c;
          chain.d <= chain.d + work.d;
          work    <= '0;
          if (final_block) begin
            state <= S_DONE;
          end else if (finishing) begin
            no_len <= 1'b0;
            state  <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!digest_valid || !digest_stall) begin
            digest_high    <= {md5de_pkg::bswap32(chain.a), md5de_pkg::bswap32(chain.b)};
            digest_low     <= {md5de_pkg::bswap32(chain.c), md5de_pkg::bswap32(chain.d)};
            digest_valid   <= 1'b1;
            chain          <= '{md5de_pkg::INIT_A, md5de_pkg::INIT_B,
                                md5de_pkg::INIT_C, md5de_pkg::INIT_D};
            bit_length     <= 64'd0;
            pos            <= 4'd0;
            marker_pending <= 1'b0;
            no_len         <= 1'b0;
            finishing      <= 1'b0;
            final_block    <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new digest is only ever launched from the done state.
  a_digest_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> $past(state == S_DONE))
    else $error("digest_valid rose outside the done state");

  // The block memory is never written while the rounds read it.
  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP || state == S_PRIME) |-> !wr_en)
    else $error("block memory written during compression");

  // The round counter is back at zero whenever an item can be taken.
  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (rnd == 6'd0))
    else $error("round counter not zero while idle");

  // The last block of a message always leads to the done state.
  a_final_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD && final_block) |=> (state == S_DONE))
    else $error("final block did not finish the message");

endmodule

[hw/rtl/md5de_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 step: the round function, the four-term add, the rotate and the
// rotation of the working registers.
// ----------------------------------------------------------------------------
module md5de_round (
  input  logic [5:0]         rnd,
  input  md5de_pkg::regs_t   cur,
  input  logic [31:0]        msg,
  output md5de_pkg::regs_t   nxt
);

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot_wide;

  always_comb begin
    case (rnd[5:4])
      2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2: f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
    t = cur.a + f + msg + md5de_pkg::ROUND_K[rnd];
    rot_wide = {t, t} << md5de_pkg::rot_amount(rnd);
    nxt.a = cur.d;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.b + rot_wide[63:32];
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Streams messages of many lengths and tail sizes into the engine, computes
// each digest independently, and compares every digest the engine delivers
// under random source gaps and sink stalls, which the last phase turns off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    bit [63:0] high;
    bit [63:0] low;
  } digest_t;

  class md5_scoreboard;
    bit [31:0] chain [4];
    bit [31:0] msg_block [16];
    bit [63:0] msg_bits;
    int unsigned fill;
    bit [31:0] sine_k [64];
    bit [4:0] shift_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                 4, 11, 16, 23, 6, 10, 15, 21};
    digest_t digest_q [$];
    int unsigned errors;

    function new();
      real s;
      for (int i = 0; i < 64; i++) begin
        s = $sin(real'(i + 1));
        if (s < 0.0) s = -s;
        sine_k[i] = 32'(longint'($floor(s * 4294967296.0)));
      end
      errors = 0;
      clear_message();
    endfunction

    function void clear_message();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      foreach (msg_block[i]) msg_block[i] = '0;
      msg_bits = '0;
      fill = 0;
    endfunction

    function void compress();
      bit [31:0] a, b, c, d, f, t;
      int g;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          f = (b & c) | (~b & d);
          g = r;
        end else if (r < 32) begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end else if (r < 48) begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end else begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
        t = a + f + msg_block[g] + sine_k[r];
        a = d;
        d = c;
        c = b;
        b = b + ((t << shift_tab[(r / 16) * 4 + r % 4]) |
                 (t >> (32 - shift_tab[(r / 16) * 4 + r % 4])));
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void push_word(bit [31:0] w);
      msg_block[fill] = w;
      fill++;
      if (fill == 16) begin
        compress();
        fill = 0;
      end
    endfunction

    function bit [31:0] swap_bytes(bit [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function void note_item(bit [31:0] w, bit [2:0] n, bit fin);
      int unsigned nb;
      digest_t dg;
      nb = (n > 4 || !fin) ? 4 : n;
      if (nb < 4) w = w & ((32'd1 << (8 * nb)) - 32'd1);
      msg_bits += 64'(8 * nb);
      if (!fin) begin
        push_word(w);
        return;
      end
      if (nb < 4) begin
        push_word(w | (32'h80 << (8 * nb)));
      end else begin
        push_word(w);
        push_word(32'h80);
      end
      if (fill > 14) begin
        while (fill != 0) push_word('0);
      end
      while (fill < 14) push_word('0);
      push_word(msg_bits[31:0]);
      push_word(msg_bits[63:32]);
      dg.high = {swap_bytes(chain[0]), swap_bytes(chain[1])};
      dg.low = {swap_bytes(chain[2]), swap_bytes(chain[3])};
      digest_q.push_back(dg);
      clear_message();
    endfunction

    function void check_digest(bit [63:0] high, bit [63:0] low);
      digest_t dg;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest high=%h low=%h", $time, high, low);
        errors++;
        return;
      end
      dg = digest_q.pop_front();
      if (high !== dg.high) begin
        $display("%0t: digest_high expected %h actual %h", $time, dg.high, high);
        errors++;
      end
      if (low !== dg.low) begin
        $display("%0t: digest_low expected %h actual %h", $time, dg.low, low);
        errors++;
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  logic        digest_valid;
  logic        digest_stall;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  md5_scoreboard sb;
  int send_idle_pct = 19;
  int recv_stall_pct = 74;
  int items_sent = 0;

  md5_digest_engine uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .data_word(data_word),
    .byte_count(byte_count),
    .last(last),
    .digest_valid(digest_valid),
    .digest_stall(digest_stall),
    .digest_high(digest_high),
    .digest_low(digest_low)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) begin
    digest_stall = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall) begin
      sb.check_digest(digest_high, digest_low);
    end
  end

  task automatic send_item(input logic [31:0] w, input logic [2:0] n, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    data_word = w;
    byte_count = n;
    last = fin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(w, n, fin);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_message(input int words, input logic [2:0] tail_count);
    logic [2:0] n;
    for (int i = 0; i < words; i++) begin
      n = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
      send_item(pick_word(), n, 1'b0);
    end
    send_item(pick_word(), tail_count, 1'b1);
  endtask

  function automatic int pick_length();
    case ($urandom_range(9))
      0, 1: return $urandom_range(13, 17);
      2: return $urandom_range(28, 70);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic [2:0] pick_tail();
    return ($urandom_range(5) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    item_valid = 1'b0;
    data_word = '0;
    byte_count = '0;
    last = 1'b0;
    digest_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int n = 0; n < 8; n++) begin
      send_item(n[0] ? 32'h0000_0000 : 32'hffff_ffff, 3'(n), 1'b1);
    end
    send_item(32'h0000_0000, 3'd4, 1'b0);
    send_item(32'hffff_ffff, 3'd1, 1'b0);
    for (int i = 0; i < 12; i++) send_item($urandom, 3'd4, 1'b0);
    send_item($urandom, 3'd1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 74 : 0;
      recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 19 : 0;
      while (items_sent < 23 + (phase + 1) * RANDOM_ITEMS / 3) begin
        send_message(pick_length(), pick_tail());
      end
    end

    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
